// File: rtl/pdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_pkg: shared types and constants of the PID duty regulator
// Register indexes, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
package pdr_pkg;

  localparam int unsigned LevelW   = 16;
  localparam int unsigned DutyW    = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LimitW   = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam int unsigned ErrW     = LevelW + 1;       // measured - target
  localparam int unsigned DErrW    = ErrW + 1;         // error - last error
  localparam int unsigned PProdW   = GainW + ErrW;     // kp * error
  localparam int unsigned IProdW   = GainW + ErrW;     // ki * error
  localparam int unsigned DProdW   = GainW + DErrW;    // kd * delta error
  localparam int unsigned IntegW   = 32;               // integral accumulator
  localparam int unsigned AccW     = IProdW + 1;       // integral before clamp
  localparam int unsigned CorrW    = 35;               // full correction, Q.8
  localparam int unsigned FracW    = 8;
  localparam int unsigned CorrIntW = CorrW - FracW;    // correction, integer
  localparam int unsigned NewDutyW = CorrIntW + 1;     // duty - correction

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP        = 3'd0,
    CFG_KI        = 3'd1,
    CFG_KD        = 3'd2,
    CFG_INT_LIMIT = 3'd3,
    CFG_DUTY_MIN  = 3'd4,
    CFG_DUTY_MAX  = 3'd5,
    CFG_TARGET    = 3'd6
  } pdr_cfg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [LimitW-1:0]       int_limit;
    logic [DutyW-1:0]        duty_min;
    logic [DutyW-1:0]        duty_max;
    logic [LevelW-1:0]       target;
  } pdr_cfg_t;

  // Pipeline load strobes handed from the top level to the stages.
  typedef struct packed {
    logic ld_a;   // input register takes a transaction
    logic ld_b;   // product register loads
    logic ld_c;   // integral register loads
    logic ld_o;   // result register loads
  } pdr_ctrl_t;

endpackage

// File: rtl/pdr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_cfg_regs: configuration register file
// Write-only registers for gains, integral bound, duty bounds and setpoint.
// ----------------------------------------------------------------------------
module pdr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pdr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pdr_pkg::CfgDataW-1:0] cfg_data_i,
  output pdr_pkg::pdr_cfg_t            cfg_o
);
  import pdr_pkg::*;

  pdr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (pdr_cfg_idx_e'(cfg_idx_i))
        CFG_KP:        cfg_d.kp        = $signed(cfg_data_i[GainW-1:0]);
        CFG_KI:        cfg_d.ki        = $signed(cfg_data_i[GainW-1:0]);
        CFG_KD:        cfg_d.kd        = $signed(cfg_data_i[GainW-1:0]);
        CFG_INT_LIMIT: cfg_d.int_limit = cfg_data_i[LimitW-1:0];
        CFG_DUTY_MIN:  cfg_d.duty_min  = cfg_data_i[DutyW-1:0];
        CFG_DUTY_MAX:  cfg_d.duty_max  = cfg_data_i[DutyW-1:0];
        CFG_TARGET:    cfg_d.target    = cfg_data_i[LevelW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp        <= '0;
      cfg_q.ki        <= '0;
      cfg_q.kd        <= '0;
      cfg_q.int_limit <= '1;
      cfg_q.duty_min  <= '0;
      cfg_q.duty_max  <= '1;
      cfg_q.target    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/pdr_error_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_error_stage: input register, error terms and gain products
// Holds the accepted sample, forms error and delta error, and registers
// the three gain products together with the duty.
// ----------------------------------------------------------------------------
module pdr_error_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pdr_pkg::pdr_ctrl_t                  ctrl_i,
  input  pdr_pkg::pdr_cfg_t                   cfg_i,
  input  logic [pdr_pkg::LevelW-1:0]          meas_i,
  input  logic [pdr_pkg::DutyW-1:0]           duty_i,
  output logic signed [pdr_pkg::PProdW-1:0]   p_prod_o,
  output logic signed [pdr_pkg::IProdW-1:0]   i_prod_o,
  output logic signed [pdr_pkg::DProdW-1:0]   d_prod_o,
  output logic [pdr_pkg::DutyW-1:0]           duty_o
);
  import pdr_pkg::*;

  logic [LevelW-1:0]       meas_q;
  logic [DutyW-1:0]        duty_a_q;
  logic signed [ErrW-1:0]  last_err_q, last_err_d;
  logic signed [ErrW-1:0]  err;
  logic signed [DErrW-1:0] derr;
  logic signed [PProdW-1:0] p_prod_q, p_prod_d;
  logic signed [IProdW-1:0] i_prod_q, i_prod_d;
  logic signed [DProdW-1:0] d_prod_q, d_prod_d;
  logic [DutyW-1:0]         duty_b_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_a) begin
      meas_q   <= meas_i;
      duty_a_q <= duty_i;
    end
  end

  always_comb begin
    err        = $signed({1'b0, meas_q}) - $signed({1'b0, cfg_i.target});
    derr       = DErrW'(err) - DErrW'(last_err_q);
    p_prod_d   = PProdW'(err) * PProdW'(cfg_i.kp);
    i_prod_d   = IProdW'(err) * IProdW'(cfg_i.ki);
    d_prod_d   = DProdW'(derr) * DProdW'(cfg_i.kd);
    last_err_d = ctrl_i.ld_b ? err : last_err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else begin
      last_err_q <= last_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_b) begin
      p_prod_q <= p_prod_d;
      i_prod_q <= i_prod_d;
      d_prod_q <= d_prod_d;
      duty_b_q <= duty_a_q;
    end
  end

  assign p_prod_o = p_prod_q;
  assign i_prod_o = i_prod_q;
  assign d_prod_o = d_prod_q;
  assign duty_o   = duty_b_q;

endmodule

// File: rtl/pdr_integral_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_integral_stage: clamped integral accumulator
// Adds the integral product to the accumulator, clamps it to the bound,
// and registers the sum of the proportional and derivative terms.
// ----------------------------------------------------------------------------
module pdr_integral_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pdr_pkg::pdr_ctrl_t                  ctrl_i,
  input  pdr_pkg::pdr_cfg_t                   cfg_i,
  input  logic signed [pdr_pkg::PProdW-1:0]   p_prod_i,
  input  logic signed [pdr_pkg::IProdW-1:0]   i_prod_i,
  input  logic signed [pdr_pkg::DProdW-1:0]   d_prod_i,
  input  logic [pdr_pkg::DutyW-1:0]           duty_i,
  output logic signed [pdr_pkg::IntegW-1:0]   integ_o,
  output logic signed [pdr_pkg::CorrW-1:0]    pd_sum_o,
  output logic [pdr_pkg::DutyW-1:0]           duty_o
);
  import pdr_pkg::*;

  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [AccW-1:0]   acc, lim_pos, lim_neg;
  logic signed [CorrW-1:0]  pd_sum_q;
  logic [DutyW-1:0]         duty_q;

  always_comb begin
    acc     = AccW'(integ_q) + AccW'(i_prod_i);
    lim_pos = $signed({{(AccW-LimitW){1'b0}}, cfg_i.int_limit});
    lim_neg = -lim_pos;
    integ_d = integ_q;
    if (ctrl_i.ld_c) begin
      priority if (acc > lim_pos) begin
        integ_d = lim_pos[IntegW-1:0];
      end else if (acc < lim_neg) begin
        integ_d = lim_neg[IntegW-1:0];
      end else begin
        integ_d = acc[IntegW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_c) begin
      pd_sum_q <= CorrW'(p_prod_i) + CorrW'(d_prod_i);
      duty_q   <= duty_i;
    end
  end

  assign integ_o  = integ_q;
  assign pd_sum_o = pd_sum_q;
  assign duty_o   = duty_q;

endmodule

// File: rtl/pdr_duty_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_duty_stage: correction, duty update and bound clamp
// Drops the fraction bits of the correction, subtracts it from the duty,
// clamps to the duty bounds and holds the result register.
// ----------------------------------------------------------------------------
module pdr_duty_stage (
  input  logic                               clk_i,
  input  pdr_pkg::pdr_ctrl_t                 ctrl_i,
  input  pdr_pkg::pdr_cfg_t                  cfg_i,
  input  logic signed [pdr_pkg::IntegW-1:0]  integ_i,
  input  logic signed [pdr_pkg::CorrW-1:0]   pd_sum_i,
  input  logic [pdr_pkg::DutyW-1:0]          duty_i,
  output logic [pdr_pkg::DutyW-1:0]          new_duty_o,
  output logic                               clamped_o
);
  import pdr_pkg::*;

  logic signed [CorrW-1:0]    corr;
  logic signed [CorrIntW-1:0] corr_int;
  logic signed [NewDutyW-1:0] nd, dmin, dmax;
  logic [DutyW-1:0]           new_duty_q, new_duty_d;
  logic                       clamped_q, clamped_d;

  always_comb begin
    corr = pd_sum_i + CorrW'(integ_i);
    // Taking the upper bits is an arithmetic shift, so it rounds down.
    corr_int = corr[CorrW-1:FracW];
    nd   = $signed({{(NewDutyW-DutyW){1'b0}}, duty_i}) - NewDutyW'(corr_int);
    dmin = $signed({{(NewDutyW-DutyW){1'b0}}, cfg_i.duty_min});
    dmax = $signed({{(NewDutyW-DutyW){1'b0}}, cfg_i.duty_max});
    priority if (nd < dmin) begin
      new_duty_d = cfg_i.duty_min;
      clamped_d  = 1'b1;
    end else if (nd > dmax) begin
      new_duty_d = cfg_i.duty_max;
      clamped_d  = 1'b1;
    end else begin
      new_duty_d = nd[DutyW-1:0];
      clamped_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_o) begin
      new_duty_q <= new_duty_d;
      clamped_q  <= clamped_d;
    end
  end

  assign new_duty_o = new_duty_q;
  assign clamped_o  = clamped_q;

endmodule

// File: rtl/pid_duty_regulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_duty_regulator_core: PID duty regulator for a buck converter
// Error, gain products, clamped integral and clamped duty in a short
// four-register pipeline.
//
//   channel  direction  tdata (low bit first)                tuser
//   s_axis   in         measured_level, current_duty         -
//   m_axis   out        new_duty                             clamped
//   cfg      in         write enable, index, data (no read)  -
//
// One transaction is taken per cycle while m_axis does not stall; an accepted
// one passes the input, product, integral and result registers in that order.
// The integral accumulator and last error update once per transaction.
// Reset clears the valid bits, the integral and the last error at once.
// A stall at m_axis backs up stage by stage; s_axis_tready falls only
// when all four registers hold a transaction.
// ----------------------------------------------------------------------------
module pid_duty_regulator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // measured_level, current_duty
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // new_duty
  output logic                         m_axis_tuser,   // clamped
  input  logic                         cfg_we_i,
  input  logic [pdr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pdr_pkg::CfgDataW-1:0] cfg_data_i
);
  import pdr_pkg::*;

  pdr_cfg_t  cfg;
  pdr_ctrl_t ctrl;

  logic v_a_q, v_b_q, v_c_q, v_o_q;
  logic v_a_d, v_b_d, v_c_d, v_o_d;

  logic signed [PProdW-1:0] p_prod;
  logic signed [IProdW-1:0] i_prod;
  logic signed [DProdW-1:0] d_prod;
  logic [DutyW-1:0]         duty_b, duty_c;
  logic signed [IntegW-1:0] integ;
  logic signed [CorrW-1:0]  pd_sum;

  // Each stage loads when it has data and the one after it is free.
  always_comb begin
    ctrl.ld_o     = v_c_q && (!v_o_q || m_axis_tready);
    ctrl.ld_c     = v_b_q && (!v_c_q || ctrl.ld_o);
    ctrl.ld_b     = v_a_q && (!v_b_q || ctrl.ld_c);
    s_axis_tready = !v_a_q || ctrl.ld_b;
    ctrl.ld_a     = s_axis_tvalid && s_axis_tready;

    v_a_d = ctrl.ld_a || (v_a_q && !ctrl.ld_b);
    v_b_d = ctrl.ld_b || (v_b_q && !ctrl.ld_c);
    v_c_d = ctrl.ld_c || (v_c_q && !ctrl.ld_o);
    v_o_d = ctrl.ld_o || (v_o_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_o_q <= 1'b0;
    end else begin
      v_a_q <= v_a_d;
      v_b_q <= v_b_d;
      v_c_q <= v_c_d;
      v_o_q <= v_o_d;
    end
  end

  pdr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pdr_error_stage u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg),
    .meas_i   (s_axis_tdata[15:0]),
    .duty_i   (s_axis_tdata[31:16]),
    .p_prod_o (p_prod),
    .i_prod_o (i_prod),
    .d_prod_o (d_prod),
    .duty_o   (duty_b)
  );

  pdr_integral_stage u_int (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg),
    .p_prod_i (p_prod),
    .i_prod_i (i_prod),
    .d_prod_i (d_prod),
    .duty_i   (duty_b),
    .integ_o  (integ),
    .pd_sum_o (pd_sum),
    .duty_o   (duty_c)
  );

  pdr_duty_stage u_duty (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg),
    .integ_i    (integ),
    .pd_sum_i   (pd_sum),
    .duty_i     (duty_c),
    .new_duty_o (m_axis_tdata),
    .clamped_o  (m_axis_tuser)
  );

  assign m_axis_tvalid = v_o_q;

endmodule

// File: rtl/pdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_checker: port-level checks of the PID duty regulator
// Watches the stream and configuration ports; keeps its own copy of the
// duty bounds to check clamped results.
// ----------------------------------------------------------------------------
module pdr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [15:0]                  m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         cfg_we_i,
  input logic [pdr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [pdr_pkg::CfgDataW-1:0] cfg_data_i
);
  import pdr_pkg::*;

  logic [DutyW-1:0] min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DUTY_MIN) begin
        min_q <= cfg_data_i[DutyW-1:0];
      end
      if (cfg_idx_i == CFG_DUTY_MAX) begin
        max_q <= cfg_data_i[DutyW-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The input side only stalls once the whole pipeline is full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty result register");

  a_flag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == min_q || m_axis_tdata == max_q)
    else $error("clamped result is not a duty bound");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && min_q <= max_q |-> m_axis_tdata >= min_q && m_axis_tdata <= max_q)
    else $error("result outside duty bounds");

endmodule

bind pid_duty_regulator_core pdr_checker u_pdr_checker (.*);
